/* rtl/fbc_pkg.sv */
package fbc_pkg;

  // plane register layout
  localparam int PLANE_W   = 64;
  localparam int NORM_W    = 12;
  localparam int OFFS_W    = 28;
  localparam int NX_LSB    = 0;
  localparam int NY_LSB    = 12;
  localparam int NZ_LSB    = 24;
  localparam int OFFS_LSB  = 36;
  localparam int OFFS_SHIFT = 10;

  // number of plane registers behind the config port, default lane count
  localparam int PLANE_REGS     = 6;
  localparam int NUM_PLANES_DEF = 6;
  localparam int CFG_IDX_W      = 3;

  // item field widths
  localparam int COORD_W = 24;
  localparam int HALF_W  = 16;

  // stream payload widths
  localparam int IN_TDATA_W  = 3 * COORD_W + HALF_W;
  localparam int OUT_TDATA_W = 8;

  // datapath widths
  localparam int PROD_W = NORM_W + COORD_W;
  localparam int ASUM_W = NORM_W + 1;
  localparam int HS_W   = HALF_W + ASUM_W;
  localparam int SUM_W  = 40;

  typedef logic [PLANE_W-1:0] plane_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_RIGHT  = 3'd0,
    REG_PLANE_LEFT   = 3'd1,
    REG_PLANE_TOP    = 3'd2,
    REG_PLANE_BOTTOM = 3'd3,
    REG_PLANE_FAR    = 3'd4,
    REG_PLANE_NEAR   = 3'd5
  } fbc_reg_e;

  function automatic logic signed [NORM_W-1:0] plane_nx(input plane_word_t p);
    return p[NX_LSB +: NORM_W];
  endfunction

  function automatic logic signed [NORM_W-1:0] plane_ny(input plane_word_t p);
    return p[NY_LSB +: NORM_W];
  endfunction

  function automatic logic signed [NORM_W-1:0] plane_nz(input plane_word_t p);
    return p[NZ_LSB +: NORM_W];
  endfunction

  function automatic logic signed [OFFS_W-1:0] plane_offs(input plane_word_t p);
    return p[OFFS_LSB +: OFFS_W];
  endfunction

endpackage

/* rtl/fbc_plane_regs.sv */
module fbc_plane_regs #(
  parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbc_pkg::PLANE_W-1:0]  cfg_wdata,
  output fbc_pkg::plane_word_t         planes_o [NUM_PLANES]
);
  import fbc_pkg::*;

  plane_word_t planes_r [PLANE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        planes_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_RIGHT:  planes_r[0] <= cfg_wdata;
        REG_PLANE_LEFT:   planes_r[1] <= cfg_wdata;
        REG_PLANE_TOP:    planes_r[2] <= cfg_wdata;
        REG_PLANE_BOTTOM: planes_r[3] <= cfg_wdata;
        REG_PLANE_FAR:    planes_r[4] <= cfg_wdata;
        REG_PLANE_NEAR:   planes_r[5] <= cfg_wdata;
        default: ; // no register behind this index
      endcase
    end
  end

  // lanes past the register file see an all-zero plane, which never rejects
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_out
    if (g < PLANE_REGS) begin : g_reg
      assign planes_o[g] = planes_r[g];
    end else begin : g_zero
      assign planes_o[g] = '0;
    end
  end

endmodule

/* rtl/fbc_plane_eval.sv */
module fbc_plane_eval (
  input  logic                                clk,
  input  logic                                en,
  input  fbc_pkg::plane_word_t                plane,
  input  logic signed [fbc_pkg::COORD_W-1:0]  cx,
  input  logic signed [fbc_pkg::COORD_W-1:0]  cy,
  input  logic signed [fbc_pkg::COORD_W-1:0]  cz,
  input  logic        [fbc_pkg::HALF_W-1:0]   half,
  output logic                                reject
);
  import fbc_pkg::*;

  logic signed [NORM_W-1:0] nx, ny, nz;
  logic signed [OFFS_W-1:0] offs;
  logic [NORM_W-1:0]        ax, ay, az;
  logic [ASUM_W-1:0]        asum;

  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic [HS_W-1:0]          hs_r, hs_nxt;
  logic signed [OFFS_W-1:0] offs_r;

  logic signed [SUM_W-1:0]  sa_r, sa_nxt, sb_r, sb_nxt;
  logic signed [SUM_W-1:0]  best;
  logic                     reject_r;

  assign nx   = plane_nx(plane);
  assign ny   = plane_ny(plane);
  assign nz   = plane_nz(plane);
  assign offs = plane_offs(plane);

  // magnitude of each normal part, unsigned so -2048 gives 2048
  assign ax   = nx[NORM_W-1] ? NORM_W'(-nx) : NORM_W'(nx);
  assign ay   = ny[NORM_W-1] ? NORM_W'(-ny) : NORM_W'(ny);
  assign az   = nz[NORM_W-1] ? NORM_W'(-nz) : NORM_W'(nz);
  assign asum = ASUM_W'(ax) + ASUM_W'(ay) + ASUM_W'(az);

  // stage 1: products
  assign px_nxt = PROD_W'(nx) * PROD_W'(cx);
  assign py_nxt = PROD_W'(ny) * PROD_W'(cy);
  assign pz_nxt = PROD_W'(nz) * PROD_W'(cz);
  assign hs_nxt = HS_W'(half) * HS_W'(asum);

  // stage 2: two partial sums, offset moved to 18 fraction bits
  assign sa_nxt = SUM_W'(px_r) + SUM_W'(py_r);
  assign sb_nxt = SUM_W'(pz_r) + $signed({{(SUM_W-HS_W){1'b0}}, hs_r})
                + $signed({{(SUM_W-OFFS_W-OFFS_SHIFT){offs_r[OFFS_W-1]}}, offs_r,
                           {OFFS_SHIFT{1'b0}}});

  // stage 3: largest corner value below zero
  assign best = sa_r + sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      pz_r     <= pz_nxt;
      hs_r     <= hs_nxt;
      offs_r   <= offs;
      sa_r     <= sa_nxt;
      sb_r     <= sb_nxt;
      reject_r <= best[SUM_W-1];
    end
  end

  assign reject = reject_r;

endmodule

/* rtl/frustum_box_cull_test.sv */
// view-frustum cull of an axis-aligned cube: each transfer carries a centre
// (signed Q16.8) and a half size (unsigned Q8.8), and returns one visible bit,
// 0 when some clip plane has all eight corners strictly behind it. planes are
// loaded over the cfg port (index 0..5: right, left, top, bottom, far, near;
// nx/ny/nz signed Q1.10 in bits 35:0, offset signed Q20.8 in bits 63:36) and
// should only be written while no box is in flight. one box is accepted per
// cycle unless a result waits while out_tready is low; the edge that accepts a
// box loads the first of four registers (the three lane stages: multiply,
// partial sums, final sum and sign; then the output register), the last of
// which presents the result. a stall on out_tready while a result waits holds
// the whole pipeline, so in_tready follows it.
module frustum_box_cull_test #(
  parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbc_pkg::PLANE_W-1:0]     cfg_wdata,
  // box input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fbc_pkg::IN_TDATA_W-1:0]  in_tdata,   // center_x, center_y, center_z, half
  // result output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fbc_pkg::OUT_TDATA_W-1:0] out_tdata   // visible, zero pad
);
  import fbc_pkg::*;

  plane_word_t planes [NUM_PLANES];

  logic signed [COORD_W-1:0] cx, cy, cz;
  logic [HALF_W-1:0]         half;
  logic [NUM_PLANES-1:0]     reject;

  // pipeline advances whenever the output register is free or being drained
  logic adv;
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic out_valid_r;
  logic visible_r;

  assign cx   = in_tdata[0 +: COORD_W];
  assign cy   = in_tdata[COORD_W +: COORD_W];
  assign cz   = in_tdata[2*COORD_W +: COORD_W];
  assign half = in_tdata[3*COORD_W +: HALF_W];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  fbc_plane_regs #(
    .NUM_PLANES (NUM_PLANES)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes_o  (planes)
  );

  // one lane per plane, all in lockstep with the valid bits below
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
    fbc_plane_eval u_eval (
      .clk    (clk),
      .en     (adv),
      .plane  (planes[g]),
      .cx     (cx),
      .cy     (cy),
      .cz     (cz),
      .half   (half),
      .reject (reject[g])
    );
  end

  // valid bits travel with the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // output register: visible unless some plane rejects
  always_ff @(posedge clk) begin
    if (adv) begin
      visible_r <= ~|reject;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, visible_r};

endmodule

/* test/tb_frustum_box_cull_test.sv */
module tb_frustum_box_cull_test;
  import fbc_pkg::*;

  // fixed-point helpers for building planes and boxes
  localparam int ONE_Q110   = 1024;          // 1.0 in signed Q1.10
  localparam int NORM_MAX   = 2047;
  localparam int NORM_MIN   = -2048;
  localparam int COORD_MAX  = 8388607;       // largest signed Q16.8 coordinate
  localparam int COORD_MIN  = -8388608;
  localparam int HALF_MAX   = 65535;
  localparam int OFFS_MAX   = 134217727;     // largest signed Q20.8 offset
  localparam int OFFS_MIN   = -134217728;

  // lanes compared by the block, and config slots with no plane behind them
  localparam int LANES = NUM_PLANES_DEF;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  // receiver stall patterns
  localparam int RDY_ALWAYS   = 0;
  localparam int RDY_COIN     = 1;
  localparam int RDY_MOSTLY   = 2;
  localparam int RDY_PERIODIC = 3;

  // idle slack after the last result before the planes are rewritten
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // one box, packed exactly as it travels on in_tdata (center_x lowest)
  typedef struct packed {
    logic [HALF_W-1:0]         half;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cx;
  } box_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [PLANE_W-1:0]     cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // center_x, center_y, center_z, half
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // visible, zero pad

  // mirror of the plane registers, as the block should hold them
  plane_word_t plane_set [PLANE_REGS] = '{default: '0};

  // expected visible bit of every box accepted but not yet answered
  logic pending_visible [$];

  int cycle_cnt   = 0;
  int err_cnt     = 0;
  int n_boxes     = 0;
  int n_visible   = 0;
  int n_culled    = 0;
  int n_settings  = 0;
  int burst_left  = 0;
  int gap_max     = 0;
  int ready_mode  = RDY_ALWAYS;

  frustum_box_cull_test #(
    .NUM_PLANES (LANES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // receiver back-pressure, pattern picked per phase
  always @(posedge clk) begin
    case (ready_mode)
      RDY_ALWAYS: begin
        out_tready <= 1'b1;
      end
      RDY_COIN: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      RDY_MOSTLY: begin
        out_tready <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        // stall whenever bits 4:2 of the cycle count are zero
        out_tready <= (cycle_cnt[4:2] != 3'd0);
      end
    endcase
  end

  // predicted visible bit: a plane culls the box when even its farthest-forward
  // corner is strictly behind it; that corner picks +h or -h per axis by the
  // sign of the normal, giving n.c + h*(|nx|+|ny|+|nz|) + w*2^10
  function automatic logic box_in_view(input box_t b);
    logic in_view;
    in_view = 1'b1;
    // lanes past the register file read as zero and never cull
    for (int p = 0; p < LANES && p < PLANE_REGS; p++) begin
      plane_word_t              pw;
      logic signed [NORM_W-1:0] nx, ny, nz;
      logic signed [OFFS_W-1:0] offs;
      longint                   ax, ay, az, reach;
      pw   = plane_set[p];
      nx   = pw[NX_LSB +: NORM_W];
      ny   = pw[NY_LSB +: NORM_W];
      nz   = pw[NZ_LSB +: NORM_W];
      offs = pw[OFFS_LSB +: OFFS_W];
      ax   = (nx < 0) ? -longint'(nx) : longint'(nx);
      ay   = (ny < 0) ? -longint'(ny) : longint'(ny);
      az   = (nz < 0) ? -longint'(nz) : longint'(nz);
      reach = longint'(nx) * longint'(b.cx) + longint'(ny) * longint'(b.cy)
            + longint'(nz) * longint'(b.cz) + longint'(b.half) * (ax + ay + az)
            + longint'(offs) * (longint'(1) << OFFS_SHIFT);
      if (reach < 0)
        in_view = 1'b0;
    end
    return in_view;
  endfunction

  function automatic plane_word_t mk_plane(input int nx, input int ny, input int nz,
                                           input int offs);
    plane_word_t pw;
    pw = '0;
    pw[NX_LSB +: NORM_W]   = nx[NORM_W-1:0];
    pw[NY_LSB +: NORM_W]   = ny[NORM_W-1:0];
    pw[NZ_LSB +: NORM_W]   = nz[NORM_W-1:0];
    pw[OFFS_LSB +: OFFS_W] = offs[OFFS_W-1:0];
    return pw;
  endfunction

  function automatic box_t mk_box(input int x, input int y, input int z, input int h);
    box_t b;
    b.cx   = x[COORD_W-1:0];
    b.cy   = y[COORD_W-1:0];
    b.cz   = z[COORD_W-1:0];
    b.half = h[HALF_W-1:0];
    return b;
  endfunction

  // coordinate scattered around a frustum of half extent r, so the box
  // straddles, clears or misses the boundary planes
  function automatic int near_coord(input int r, input int h);
    int span;
    span = r + r / 2 + 2 * h + 64;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // one box transfer; the sender runs in bursts with random gaps between them
  task automatic send_box(input box_t b);
    int  gap;
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    // handshake level is settled by the falling edge and holds to the next rise
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    pending_visible.push_back(box_in_view(b));
    n_boxes++;
  endtask

  // drop valid and wait until every box has been answered
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_visible.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, with cfg_we dropped again before the task returns, mirror updated alongside
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input plane_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    // unmapped slots are dropped by the block
    if (idx < PLANE_REGS)
      plane_set[idx] = val;
  endtask

  task automatic clear_planes();
    for (int p = 0; p < PLANE_REGS; p++)
      write_reg(p[CFG_IDX_W-1:0], '0);
  endtask

  // result check: each transfer against the oldest prediction
  always @(negedge clk) begin
    logic exp_vis;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_visible.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no box outstanding, actual tdata %h", $time, out_tdata);
      end else begin
        exp_vis = pending_visible.pop_front();
        if (out_tdata !== OUT_TDATA_W'(exp_vis)) begin
          err_cnt++;
          $display("%0t: visible mismatch, expected %0d actual %0d (tdata %h)",
                   $time, exp_vis, out_tdata[0], out_tdata);
        end
        if (exp_vis)
          n_visible++;
        else
          n_culled++;
      end
    end
  end

  // planes are all zero after reset, so nothing may be culled
  task automatic test_reset_planes();
    ready_mode = RDY_COIN;
    gap_max    = 3;
    n_settings++;
    send_box(mk_box(0, 0, 0, 0));
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, HALF_MAX));
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, 0));
  endtask

  // corner value of exactly zero is not behind the plane, one lsb below is
  task automatic test_plane_edge();
    wait_drained();
    write_reg(REG_PLANE_RIGHT, mk_plane(1, 0, 0, 0));
    n_settings++;
    send_box(mk_box(-1, 0, 0, 0));      // corner at -1: culled
    send_box(mk_box(-1, 0, 0, 1));      // corner touches zero: kept
    send_box(mk_box(0, 0, 0, 0));
    wait_drained();
    write_reg(REG_PLANE_RIGHT, mk_plane(ONE_Q110, 0, 0, 0));
    n_settings++;
    send_box(mk_box(-300, 5, -5, 300)); // face lies on the plane
    send_box(mk_box(-301, 5, -5, 300));
  endtask

  // extreme normals, offsets and box fields
  task automatic test_field_extremes();
    wait_drained();
    clear_planes();
    // every bit set: normals and offset all at -1 lsb
    write_reg(REG_PLANE_NEAR, '1);
    n_settings++;
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, 0));
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, 0));
    send_box(mk_box(0, 0, 0, HALF_MAX));
    send_box(mk_box(0, 0, 0, 0));
    wait_drained();
    write_reg(REG_PLANE_NEAR, '0);
    write_reg(REG_PLANE_FAR, mk_plane(NORM_MIN, NORM_MIN, NORM_MIN, OFFS_MAX));
    n_settings++;
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, 0));
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, HALF_MAX));
    wait_drained();
    // most negative offset outweighs any box: always culls
    write_reg(REG_PLANE_TOP, mk_plane(NORM_MAX, NORM_MAX, NORM_MAX, OFFS_MIN));
    n_settings++;
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, HALF_MAX));
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, 0));
  endtask

  // writes past the last plane register must not take effect
  task automatic test_unmapped_index();
    wait_drained();
    clear_planes();
    write_reg(IDX_UNMAPPED_LO, mk_plane(0, 0, 0, OFFS_MIN));
    write_reg(IDX_UNMAPPED_HI, mk_plane(0, 0, 0, OFFS_MIN));
    n_settings++;
    send_box(mk_box(0, 0, 0, 0));
    send_box(mk_box(COORD_MAX, COORD_MIN, COORD_MAX, HALF_MAX));
    send_box(mk_box(-12345, 6789, 1, 255));
  endtask

  // realistic frusta, axis aligned or tilted, with boxes scattered around them
  task automatic test_frustum_sweep();
    int   r, rz, h;
    box_t b;
    for (int s = 0; s < 8; s++) begin
      wait_drained();
      r  = $urandom_range(16, 1 << 20);
      rz = $urandom_range(16, 1 << 20);
      if (s % 2 == 0) begin
        write_reg(REG_PLANE_RIGHT,  mk_plane(-ONE_Q110, 0, 0, r));
        write_reg(REG_PLANE_LEFT,   mk_plane(ONE_Q110, 0, 0, r));
        write_reg(REG_PLANE_TOP,    mk_plane(0, -ONE_Q110, 0, r));
        write_reg(REG_PLANE_BOTTOM, mk_plane(0, ONE_Q110, 0, r));
        write_reg(REG_PLANE_FAR,    mk_plane(0, 0, -ONE_Q110, rz));
        write_reg(REG_PLANE_NEAR,   mk_plane(0, 0, ONE_Q110, rz));
      end else begin
        rz = r;
        for (int p = 0; p < PLANE_REGS; p++)
          write_reg(p[CFG_IDX_W-1:0],
                    mk_plane(int'($urandom_range(0, 4095)) + NORM_MIN,
                             int'($urandom_range(0, 4095)) + NORM_MIN,
                             int'($urandom_range(0, 4095)) + NORM_MIN,
                             $urandom_range(0, 6 * r)));
      end
      n_settings++;
      // first and sixth setting run with no gaps and no stalls
      ready_mode = (s == 0 || s == 5) ? RDY_ALWAYS : s % 4;
      gap_max    = (s == 0 || s == 5) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < 150; k++) begin
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, HALF_MAX)
                                        : $urandom_range(0, 4095);
        if ($urandom_range(0, 9) < 8)
          b = mk_box(near_coord(r, h), near_coord(r, h), near_coord(rz, h), h);
        else
          b = mk_box($urandom(), $urandom(), $urandom(), $urandom());
        send_box(b);
      end
    end
  endtask

  // arbitrary plane words, about half of the planes left at zero
  task automatic test_random_planes();
    int   h;
    box_t b;
    for (int s = 0; s < 6; s++) begin
      wait_drained();
      for (int p = 0; p < PLANE_REGS; p++)
        write_reg(p[CFG_IDX_W-1:0],
                  $urandom_range(0, 1) ? {$urandom(), $urandom()} : plane_word_t'(0));
      n_settings++;
      ready_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
      gap_max    = $urandom_range(0, 6);
      for (int k = 0; k < 95; k++) begin
        h = $urandom_range(0, HALF_MAX);
        if ($urandom_range(0, 1))
          b = mk_box(near_coord(1 << 20, h), near_coord(1 << 20, h),
                     near_coord(1 << 20, h), h);
        else
          b = mk_box($urandom(), $urandom(), $urandom(), h);
        send_box(b);
      end
    end
  endtask

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_visible.size());
    $display("tb_frustum_box_cull_test NOT OK");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_planes();
    test_plane_edge();
    test_field_extremes();
    test_unmapped_index();
    test_frustum_sweep();
    test_random_planes();
    wait_drained();

    $display("covered %0d boxes over %0d plane settings: %0d visible, %0d culled",
             n_boxes, n_settings, n_visible, n_culled);
    $display("mismatches: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("tb_frustum_box_cull_test OK");
    end else begin
      $display("tb_frustum_box_cull_test NOT OK");
    end
    $finish;
  end

endmodule
